[rtl/glos_pkg.sv]
// Package for the grid line-of-sight block: widths, codes and the structs
// that run between the sequencer, the divider and the cell store.
// No dependencies.
`timescale 1ns / 1ps

package glos_pkg;

  localparam int ADDR_W        = 12;
  localparam int MAP_DEPTH     = 2 ** ADDR_W;
  localparam int CFG_W         = 7;
  localparam int CFG_MAX       = 2 ** CFG_W - 1;
  localparam int CFG_INDEX_W   = 2;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;
  } map_req_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [CFG_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
    logic [CFG_W-1:0]  remainder;
  } div_rsp_t;

endpackage

[rtl/glos_div.sv]
// Restoring divider, one quotient bit per cycle: splits a linear cell index
// into row (quotient) and column (remainder). Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_div (
  input  logic              clk,
  input  logic              rst,
  input  glos_pkg::div_req_t req,
  output glos_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(glos_pkg::ADDR_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(glos_pkg::ADDR_W - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [glos_pkg::CFG_W-1:0]    divisor;
  logic [glos_pkg::CFG_W-1:0]    rem;
  logic [glos_pkg::ADDR_W-1:0]   quo;
  logic                          done;

  logic [glos_pkg::CFG_W:0]      trial;
  logic                          fits;
  logic [glos_pkg::CFG_W:0]      diff;

  assign trial = {rem, quo[glos_pkg::ADDR_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= CNT_LAST;
        divisor <= req.divisor;
        rem     <= '0;
        quo     <= req.dividend;
      end else if (busy) begin
        rem <= fits ? diff[glos_pkg::CFG_W-1:0] : trial[glos_pkg::CFG_W-1:0];
        quo <= {quo[glos_pkg::ADDR_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[rtl/glos_map.sv]
// Passability store, one bit per cell, one write and one registered read
// port. Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_map (
  input  logic              clk,
  input  glos_pkg::map_req_t req,
  output logic              rdata
);

  logic mem [glos_pkg::MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[rtl/grid_line_of_sight.sv]
// Grid line-of-sight top level: configuration registers, query sequencer
// and output register. Depends on glos_pkg, glos_div and glos_map.
`timescale 1ns / 1ps

// After reset the block sweeps the 4096-cell store to blocked, one cell a
// cycle, and holds in_stall high for the whole sweep; configuration writes
// are taken throughout. A cell write does not stall the input. A query
// holds in_stall high from its transfer until its result is registered:
// the shared divider makes the two index splits in turn, then the walk
// reads one cell a cycle over the max(|dx|,|dy|)+1 line cells from the
// single read port of the store. A query on a zero width or height answers
// not clear. The result sits in an output register, so the next item is
// taken while it waits.

module grid_line_of_sight #(
  parameter int MAX_WIDTH  = glos_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = glos_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [glos_pkg::ADDR_W-1:0]      cell_addr,
  input  logic                             cell_passable,
  input  logic [glos_pkg::ADDR_W-1:0]      start_cell,
  input  logic [glos_pkg::ADDR_W-1:0]      end_cell,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             line_clear,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [glos_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [glos_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW = glos_pkg::ADDR_W;
  localparam int CW = glos_pkg::CFG_W;
  localparam int W_CAP = (MAX_WIDTH > glos_pkg::CFG_MAX) ? glos_pkg::CFG_MAX : MAX_WIDTH;
  localparam int H_CAP = (MAX_HEIGHT > glos_pkg::CFG_MAX) ? glos_pkg::CFG_MAX : MAX_HEIGHT;
  localparam logic [CW-1:0] W_LIM = W_CAP[CW-1:0];
  localparam logic [CW-1:0] H_LIM = H_CAP[CW-1:0];
  localparam int ERR_W = AW + 2;
  localparam logic signed [ERR_W-1:0] ONE_S = ERR_W'(1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV_S, S_DIV_E, S_SETUP, S_PREP, S_WALK, S_DRAIN, S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0]   grid_width;
  logic [CW-1:0]   grid_height;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   start_q;
  logic [AW-1:0]   end_q;
  logic [CW-1:0]   x;
  logic [AW-1:0]   y;
  logic [CW-1:0]   x1;
  logic [AW-1:0]   y1;
  logic [CW-1:0]   dx;
  logic [AW-1:0]   dy;
  logic            sx;
  logic            sy;
  logic signed [ERR_W-1:0] err;
  logic [AW:0]     lin;
  logic            blocked;
  logic            rd_pending;

  logic [CW-1:0]   w_eff;
  logic [CW-1:0]   h_eff;
  logic            in_xfer;
  logic            degenerate;
  logic            oob;
  logic            at_end;
  logic signed [ERR_W:0]   e2;
  logic            step_x;
  logic            step_y;
  logic signed [ERR_W-1:0] err_next;
  logic signed [ERR_W-1:0] lin_next;
  logic signed [ERR_W-1:0] dx_s;
  logic signed [ERR_W-1:0] dy_s;
  logic signed [ERR_W-1:0] w_s;
  logic            rdata;

  glos_pkg::map_req_t map_req;
  glos_pkg::div_req_t div_req;
  glos_pkg::div_rsp_t div_rsp;

  glos_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  glos_map u_map (
    .clk   (clk),
    .req   (map_req),
    .rdata (rdata)
  );

  assign w_eff      = (grid_width > W_LIM) ? W_LIM : grid_width;
  assign h_eff      = (grid_height > H_LIM) ? H_LIM : grid_height;
  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_xfer    = in_valid && !in_stall;
  assign degenerate = (w_eff == '0) || (h_eff == '0);

  assign oob    = (y >= {{(AW-CW){1'b0}}, h_eff}) || lin[AW];
  assign at_end = (x == x1) && (y == y1);
  assign dx_s   = $signed({{(ERR_W-CW){1'b0}}, dx});
  assign dy_s   = $signed({{(ERR_W-AW){1'b0}}, dy});
  assign w_s    = $signed({{(ERR_W-CW){1'b0}}, w_eff});
  assign e2     = {err, 1'b0};
  assign step_x = e2 > -$signed({dy_s[ERR_W-1], dy_s});
  assign step_y = e2 < $signed({dx_s[ERR_W-1], dx_s});

  always_comb begin
    err_next = err;
    lin_next = $signed({1'b0, lin});
    if (step_x) begin
      err_next = err_next - dy_s;
      lin_next = sx ? lin_next + ONE_S : lin_next - ONE_S;
    end
    if (step_y) begin
      err_next = err_next + dx_s;
      lin_next = sy ? lin_next + w_s : lin_next - w_s;
    end
  end

  always_comb begin
    map_req.we    = 1'b0;
    map_req.waddr = cell_addr;
    map_req.wdata = cell_passable;
    map_req.raddr = lin[AW-1:0];
    if (state == S_CLEAR) begin
      map_req.we    = 1'b1;
      map_req.waddr = clr_addr;
      map_req.wdata = 1'b0;
    end else if (in_xfer && cmd == glos_pkg::CMD_WRITE) begin
      map_req.we = 1'b1;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = start_cell;
    div_req.divisor  = w_eff;
    if (in_xfer && cmd == glos_pkg::CMD_QUERY && !degenerate) begin
      div_req.start = 1'b1;
    end else if (state == S_DIV_S && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = end_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      grid_width  <= glos_pkg::GRID_RESET;
      grid_height <= glos_pkg::GRID_RESET;
      out_valid   <= 1'b0;
      blocked     <= 1'b0;
      rd_pending  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == glos_pkg::CFG_GRID_WIDTH) begin
          grid_width <= cfg_data;
        end else if (cfg_index == glos_pkg::CFG_GRID_HEIGHT) begin
          grid_height <= cfg_data;
        end
      end

      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          rd_pending <= 1'b0;
          if (in_xfer && cmd == glos_pkg::CMD_QUERY) begin
            start_q <= start_cell;
            end_q   <= end_cell;
            blocked <= degenerate;
            state   <= degenerate ? S_DONE : S_DIV_S;
          end
        end
        S_DIV_S: begin
          if (div_rsp.done) begin
            x     <= div_rsp.remainder;
            y     <= div_rsp.quotient;
            state <= S_DIV_E;
          end
        end
        S_DIV_E: begin
          if (div_rsp.done) begin
            x1    <= div_rsp.remainder;
            y1    <= div_rsp.quotient;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          dx    <= (x > x1) ? x - x1 : x1 - x;
          dy    <= (y > y1) ? y - y1 : y1 - y;
          sx    <= x < x1;
          sy    <= y < y1;
          lin   <= {1'b0, start_q};
          state <= S_PREP;
        end
        S_PREP: begin
          err   <= dx_s - dy_s;
          state <= S_WALK;
        end
        S_WALK: begin
          rd_pending <= !oob;
          if (oob || (rd_pending && !rdata)) begin
            blocked <= 1'b1;
          end
          if (at_end) begin
            state <= S_DRAIN;
          end else begin
            err <= err_next;
            lin <= lin_next[AW:0];
            if (step_x) begin
              x <= sx ? x + 1'b1 : x - 1'b1;
            end
            if (step_y) begin
              y <= sy ? y + 1'b1 : y - 1'b1;
            end
          end
        end
        S_DRAIN: begin
          rd_pending <= 1'b0;
          if (rd_pending && !rdata) begin
            blocked <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            line_clear <= !blocked;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/glos_checker.sv]
// Port-level checks for grid_line_of_sight, bound to the top level.
// Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             cmd,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             line_clear,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_clear))
    else $error("stalled result changed");

  // a query transfer keeps the input busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == glos_pkg::CMD_QUERY |=> in_stall)
    else $error("input not busy after query transfer");

  // reset starts the clearing sweep with no result pending
  assert property (@(posedge clk) rst |=> in_stall && !out_valid)
    else $error("reset did not start clearing sweep");

  // configuration writes are always taken
  assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind grid_line_of_sight glos_checker u_glos_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .cmd        (cmd),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .line_clear (line_clear),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

[verif/testbench.sv]
// Testbench for grid_line_of_sight: a directed table, then random phases of
// grid sizes, map writes and line-of-sight queries, checked against an
// in-bench predictor. Depends on glos_pkg and the grid_line_of_sight RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS    = 1000;
  localparam int PHASE_ITEMS     = 48;
  localparam int SETTLE_CYCLES   = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT     = 20000;

  localparam logic [glos_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [glos_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {STEP_ITEM, STEP_REG} step_kind_t;

  typedef struct packed {
    step_kind_t                       kind;
    logic                             cmd;
    logic [glos_pkg::ADDR_W-1:0]      addr;
    logic                             pass;
    logic [glos_pkg::ADDR_W-1:0]      from_cell;
    logic [glos_pkg::ADDR_W-1:0]      to_cell;
    logic [glos_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [glos_pkg::CFG_W-1:0]       reg_value;
    logic                             typed;
    logic                             typed_clear;
  } step_t;

  typedef struct packed {
    logic predicted;
    logic typed;
    logic typed_clear;
  } clear_entry_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             cmd = glos_pkg::CMD_WRITE;
  logic [glos_pkg::ADDR_W-1:0]      cell_addr = '0;
  logic                             cell_passable = 1'b0;
  logic [glos_pkg::ADDR_W-1:0]      start_cell = '0;
  logic [glos_pkg::ADDR_W-1:0]      end_cell = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             line_clear;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [glos_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [glos_pkg::CFG_W-1:0]       cfg_data = '0;

  logic row_typed = 1'b0;
  logic row_typed_clear = 1'b0;

  bit                         passable_cells [glos_pkg::MAP_DEPTH];
  logic [glos_pkg::CFG_W-1:0] grid_cols = glos_pkg::GRID_RESET;
  logic [glos_pkg::CFG_W-1:0] grid_rows = glos_pkg::GRID_RESET;
  clear_entry_t               clear_expected [$];

  int error_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit feed_burst = 1'b0;
  bit drain_burst = 1'b0;
  bit pressure_req = 1'b0;

  grid_line_of_sight dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .cell_addr    (cell_addr),
    .cell_passable(cell_passable),
    .start_cell   (start_cell),
    .end_cell     (end_cell),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_clear   (line_clear),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic predict_line_clear(input logic [glos_pkg::ADDR_W-1:0] from_cell,
                                              input logic [glos_pkg::ADDR_W-1:0] to_cell);
    int   cols, rows, x, y, x1, y1, dx, dy, sx, sy, err, e2, lin;
    logic clear;
    bit   walking;
    cols = (grid_cols > glos_pkg::MAX_WIDTH_DEF) ? glos_pkg::MAX_WIDTH_DEF : int'(grid_cols);
    rows = (grid_rows > glos_pkg::MAX_HEIGHT_DEF) ? glos_pkg::MAX_HEIGHT_DEF : int'(grid_rows);
    if (cols == 0 || rows == 0) begin
      return 1'b0;
    end
    x  = int'(from_cell) % cols;
    y  = int'(from_cell) / cols;
    x1 = int'(to_cell) % cols;
    y1 = int'(to_cell) / cols;
    dx = (x1 > x) ? x1 - x : x - x1;
    dy = (y1 > y) ? y1 - y : y - y1;
    sx = (x < x1) ? 1 : -1;
    sy = (y < y1) ? 1 : -1;
    err = dx - dy;
    clear = 1'b1;
    walking = 1'b1;
    while (walking) begin
      lin = y * cols + x;
      if (x < 0 || y < 0 || x >= cols || y >= rows || lin >= glos_pkg::MAP_DEPTH ||
          !passable_cells[lin]) begin
        clear = 1'b0;
        walking = 1'b0;
      end else if (x == x1 && y == y1) begin
        walking = 1'b0;
      end else begin
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y += sy;
        end
      end
    end
    return clear;
  endfunction

  function automatic step_t item_write(input logic [glos_pkg::ADDR_W-1:0] addr,
                                       input logic pass);
    step_t st;
    st = '0;
    st.kind = STEP_ITEM;
    st.cmd = glos_pkg::CMD_WRITE;
    st.addr = addr;
    st.pass = pass;
    st.from_cell = glos_pkg::ADDR_W'($urandom);
    st.to_cell = glos_pkg::ADDR_W'($urandom);
    return st;
  endfunction

  function automatic step_t item_query(input logic [glos_pkg::ADDR_W-1:0] from_cell,
                                       input logic [glos_pkg::ADDR_W-1:0] to_cell,
                                       input logic typed, input logic typed_clear);
    step_t st;
    st = '0;
    st.kind = STEP_ITEM;
    st.cmd = glos_pkg::CMD_QUERY;
    st.addr = glos_pkg::ADDR_W'($urandom);
    st.pass = 1'($urandom);
    st.from_cell = from_cell;
    st.to_cell = to_cell;
    st.typed = typed;
    st.typed_clear = typed_clear;
    return st;
  endfunction

  function automatic step_t reg_write(input logic [glos_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [glos_pkg::CFG_W-1:0] value);
    step_t st;
    st = '0;
    st.kind = STEP_REG;
    st.reg_index = idx;
    st.reg_value = value;
    return st;
  endfunction

  function automatic logic [glos_pkg::CFG_W-1:0] pick_dim();
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0:       return '0;
      1:       return glos_pkg::CFG_W'(glos_pkg::MAX_WIDTH_DEF);
      2:       return glos_pkg::CFG_W'($urandom_range(glos_pkg::MAX_WIDTH_DEF + 1,
                                                      glos_pkg::CFG_MAX));
      3:       return glos_pkg::CFG_W'(1);
      default: return glos_pkg::CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic check_bit(input string what, input logic got, input logic want);
    if (got !== want) begin
      $display("%0t: %s: line_clear %b, expected %b", $time, what, got, want);
      error_count++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (clear_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [glos_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [glos_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      glos_pkg::CFG_GRID_WIDTH:  grid_cols = value;
      glos_pkg::CFG_GRID_HEIGHT: grid_rows = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input step_t st);
    int gap;
    gap = feed_burst ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= st.cmd;
    cell_addr <= st.addr;
    cell_passable <= st.pass;
    start_cell <= st.from_cell;
    end_cell <= st.to_cell;
    row_typed <= st.typed;
    row_typed_clear <= st.typed_clear;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic run_step(input step_t st);
    if (st.kind == STEP_REG) begin
      settle();
      write_reg(st.reg_index, st.reg_value);
    end else begin
      send_item(st);
    end
  endtask

  task automatic run_random_phase(input int phase);
    logic [glos_pkg::CFG_W-1:0] wv, hv;
    int                         cols, rows, area, pick;
    wv = pick_dim();
    hv = pick_dim();
    settle();
    write_reg(glos_pkg::CFG_GRID_WIDTH, wv);
    write_reg(glos_pkg::CFG_GRID_HEIGHT, hv);
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                glos_pkg::CFG_W'($urandom));
    end
    cols = (wv > glos_pkg::MAX_WIDTH_DEF) ? glos_pkg::MAX_WIDTH_DEF : int'(wv);
    rows = (hv > glos_pkg::MAX_HEIGHT_DEF) ? glos_pkg::MAX_HEIGHT_DEF : int'(hv);
    area = cols * rows;
    feed_burst = ($urandom_range(0, 3) == 0);
    drain_burst = ($urandom_range(0, 3) == 0);
    if (phase % 4 == 1) begin
      pressure_req = 1'b1;
    end
    // on a grid of up to 64 cells, open up most cells so that lines get past the first cell
    if (area > 0 && area <= 64) begin
      for (int c = 0; c < area; c++) begin
        send_item(item_write(glos_pkg::ADDR_W'(c), $urandom_range(0, 7) != 0));
      end
    end else begin
      repeat (24) begin
        send_item(item_write(area > 0 ? glos_pkg::ADDR_W'($urandom_range(0, area - 1)) :
                             glos_pkg::ADDR_W'($urandom), $urandom_range(0, 7) != 0));
      end
    end
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(item_write(glos_pkg::ADDR_W'($urandom), 1'($urandom)));
      end else if (pick == 1 || area == 0) begin
        send_item(item_query(glos_pkg::ADDR_W'($urandom), glos_pkg::ADDR_W'($urandom),
                             1'b0, 1'b0));
      end else if (pick == 2) begin
        send_item(item_write(glos_pkg::ADDR_W'($urandom_range(0, area - 1)),
                             $urandom_range(0, 7) != 0));
      end else begin
        send_item(item_query(glos_pkg::ADDR_W'($urandom_range(0, area - 1)),
                             glos_pkg::ADDR_W'($urandom_range(0, area - 1)), 1'b0, 1'b0));
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    clear_entry_t head;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (clear_expected.size() == 0) begin
          check_bit("result with no query pending", line_clear, 1'bx);
        end else begin
          head = clear_expected.pop_front();
          check_bit("line_clear vs prediction", line_clear, head.predicted);
          if (head.typed) begin
            check_bit("line_clear vs table", line_clear, head.typed_clear);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (cmd == glos_pkg::CMD_QUERY) begin
          head.predicted = predict_line_clear(start_cell, end_cell);
          head.typed = row_typed;
          head.typed_clear = row_typed_clear;
          clear_expected.insert(clear_expected.size(), head);
        end else begin
          passable_cells[cell_addr] = cell_passable;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : receiver
    int hold;
    forever begin
      hold = drain_burst ? 0 : $urandom_range(0, 3);
      if (pressure_req) begin
        hold = HOLD_OFF_CYCLES;
        pressure_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin : stimulus
    step_t plan [$];
    int    phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    plan.insert(plan.size(), item_query(12'd0, 12'd0, 1'b1, 1'b0));
    plan.insert(plan.size(), item_write(12'd0, 1'b1));
    plan.insert(plan.size(), item_query(12'd0, 12'd0, 1'b1, 1'b1));
    plan.insert(plan.size(), item_write(12'd4095, 1'b1));
    plan.insert(plan.size(), item_query(12'd4095, 12'd4095, 1'b1, 1'b1));
    plan.insert(plan.size(), item_query(12'd0, 12'd4095, 1'b1, 1'b0));
    plan.insert(plan.size(), item_write(12'd1, 1'b1));
    plan.insert(plan.size(), item_write(12'd2, 1'b1));
    plan.insert(plan.size(), item_query(12'd0, 12'd2, 1'b1, 1'b1));
    plan.insert(plan.size(), item_query(12'd2, 12'd0, 1'b1, 1'b1));
    plan.insert(plan.size(), item_query(12'd0, 12'd3, 1'b1, 1'b0));
    plan.insert(plan.size(), item_write(12'd4095, 1'b0));
    plan.insert(plan.size(), item_query(12'd4095, 12'd4095, 1'b1, 1'b0));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_WIDTH, 7'd0));
    plan.insert(plan.size(), item_query(12'd0, 12'd0, 1'b1, 1'b0));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_WIDTH, 7'd127));
    plan.insert(plan.size(), item_query(12'd0, 12'd2, 1'b1, 1'b1));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_HEIGHT, 7'd0));
    plan.insert(plan.size(), item_query(12'd0, 12'd0, 1'b1, 1'b0));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_HEIGHT, 7'd127));
    plan.insert(plan.size(), item_query(12'd0, 12'd64, 1'b0, 1'b0));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_WIDTH, 7'd2));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_HEIGHT, 7'd1));
    plan.insert(plan.size(), item_query(12'd0, 12'd1, 1'b1, 1'b1));
    plan.insert(plan.size(), item_query(12'd0, 12'd2, 1'b1, 1'b0));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_WIDTH, 7'd1));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_HEIGHT, 7'd64));
    plan.insert(plan.size(), item_query(12'd0, 12'd2, 1'b1, 1'b1));
    plan.insert(plan.size(), item_query(12'd4095, 12'd0, 1'b1, 1'b0));
    plan.insert(plan.size(), reg_write(CFG_SPARE_A, 7'd127));
    plan.insert(plan.size(), reg_write(CFG_SPARE_B, 7'd0));
    plan.insert(plan.size(), item_query(12'd0, 12'd2, 1'b1, 1'b1));
    plan.insert(plan.size(), item_write(12'hAAA, 1'b1));
    plan.insert(plan.size(), item_write(12'h555, 1'b0));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_WIDTH, 7'd64));
    plan.insert(plan.size(), reg_write(glos_pkg::CFG_GRID_HEIGHT, 7'd64));
    plan.insert(plan.size(), item_query(12'h555, 12'hAAA, 1'b0, 1'b0));

    foreach (plan[i]) begin
      run_step(plan[i]);
    end

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      run_random_phase(phase);
      phase++;
    end
    settle();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/glos_pkg.sv
rtl/glos_div.sv
rtl/glos_map.sv
rtl/grid_line_of_sight.sv
rtl/glos_checker.sv
verif/testbench.sv
